// File: hdl/mahalanobis_nearest_neighbor_assoc_assert.svh
// Assertion macros used by the checker of the association block.
`ifndef MAHALANOBIS_NEAREST_NEIGHBOR_ASSOC_ASSERT_SVH
`define MAHALANOBIS_NEAREST_NEIGHBOR_ASSOC_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MNNA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mnna assertion failed");

// Next-cycle implication, disabled during reset.
`define MNNA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mnna assertion failed");

`endif

// File: hdl/mnna_pkg.sv
// ---------------------------------------------------------------------------
// mnna_pkg
// Types and constants of the greedy nearest-neighbor association block.
// ---------------------------------------------------------------------------
package mnna_pkg;

  localparam int POS_W       = 16;
  localparam int VAR_W       = 16;
  localparam int THR_W       = 16;
  localparam int IDX_W       = 5;
  localparam int SQ_W        = 32;
  localparam int DIST_W      = 34;
  localparam int PAIR_W      = 6;
  localparam int RESULT_LIMIT = 32;
  localparam int DIV_STEP_W  = 6;

  localparam logic [THR_W-1:0]  THRESH_RESET = 16'd1152;
  localparam logic [DIST_W-1:0] DIST_SAT     = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    OP_TRACK = 2'd0,
    OP_DET   = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [VAR_W-1:0] var_x;
    logic [VAR_W-1:0] var_y;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] det_index;
    logic [IDX_W-1:0] track_index;
    logic             matched;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [VAR_W-1:0] vx;
    logic [VAR_W-1:0] vy;
  } trk_rec_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } det_rec_t;

  typedef struct packed {
    logic load_trk;
    logic load_det;
    logic run_start;
    logic t_rd;
    logic t_next;
    logic d_rd;
    logic d_next;
    logic sq_en;
    logic div_start;
    logic upd;
    logic pair;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic t_done;
    logic d_done;
    logic taken;
    logic gate_pass;
    logic var_zero;
    logic div_busy;
    logic pair_ok;
    logic pend_valid;
    logic out_free;
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_T_CHK,
    S_D_CHK,
    S_D_SQ,
    S_D_GATE,
    S_D_DIV,
    S_T_END,
    S_FIN
  } state_t;

endpackage

// File: hdl/mahalanobis_nearest_neighbor_assoc.sv
// A load (track or detection) is accepted while idle; a run holds the input until it ends.
// A run checks each track against each detection: a taken one is skipped, one
// outside the Euclidean gate or with zero variance needs no division, else the
// 32-step divider runs; closing emits the last word. Output stalls lengthen a run.
// Synchronous reset clears the counts, taken bits and output; the threshold
// returns to 1152. Track and detection memories are not cleared.
// ---------------------------------------------------------------------------
// mahalanobis_nearest_neighbor_assoc
// Greedy nearest-neighbor track to detection association with a gate on the
// squared Mahalanobis distance of diagonal covariance.
// ---------------------------------------------------------------------------
module mahalanobis_nearest_neighbor_assoc #(
  parameter int MAX_TRACKS     = 32,
  parameter int MAX_DETECTIONS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mnna_pkg::item_t             item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mnna_pkg::result_t           result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mnna_pkg::THR_W-1:0]  cfg_data
);

  mnna_pkg::cmd_t    cmd;
  mnna_pkg::status_t stat;

  assign cfg_ready = 1'b1;

  mnna_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (item.op),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  mnna_dp #(
    .MAX_TRACKS     (MAX_TRACKS),
    .MAX_DETECTIONS (MAX_DETECTIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .result    (result)
  );

endmodule

// File: hdl/mnna_div.sv
// ---------------------------------------------------------------------------
// mnna_div
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit unsigned.
// ---------------------------------------------------------------------------
module mnna_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mnna_pkg::SQ_W-1:0]      dividend,
  input  logic [mnna_pkg::VAR_W-1:0]     divisor,
  output logic                           busy,
  output logic [mnna_pkg::SQ_W-1:0]      quotient
);

  logic [mnna_pkg::VAR_W-1:0]      rem;
  logic [mnna_pkg::DIV_STEP_W-1:0] cnt;
  logic [mnna_pkg::VAR_W:0]        rem_sh;
  logic [mnna_pkg::VAR_W+1:0]      diff;

  assign rem_sh = {rem, quotient[mnna_pkg::SQ_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= mnna_pkg::DIV_STEP_W'(mnna_pkg::SQ_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == mnna_pkg::DIV_STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[mnna_pkg::VAR_W+1]) begin
        rem      <= diff[mnna_pkg::VAR_W-1:0];
        quotient <= {quotient[mnna_pkg::SQ_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[mnna_pkg::VAR_W-1:0];
        quotient <= {quotient[mnna_pkg::SQ_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/mnna_dp.sv
// ---------------------------------------------------------------------------
// mnna_dp
// Datapath: track and detection memories, distance arithmetic, best-match
// tracking, pending pair and the output register.
// ---------------------------------------------------------------------------
module mnna_dp #(
  parameter int MAX_TRACKS     = 32,
  parameter int MAX_DETECTIONS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mnna_pkg::cmd_t              cmd,
  output mnna_pkg::status_t           stat,
  input  mnna_pkg::item_t             item,
  input  logic                        cfg_valid,
  input  logic [mnna_pkg::THR_W-1:0]  cfg_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output mnna_pkg::result_t           result
);

  localparam int TCW = $clog2(MAX_TRACKS + 1);
  localparam int TAW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int DCW = $clog2(MAX_DETECTIONS + 1);
  localparam int DAW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;

  mnna_pkg::trk_rec_t trk_mem [MAX_TRACKS];
  mnna_pkg::det_rec_t det_mem [MAX_DETECTIONS];
  mnna_pkg::trk_rec_t trk_q;
  mnna_pkg::det_rec_t det_q;
  logic [MAX_DETECTIONS-1:0] taken;
  logic                      taken_q;

  logic [mnna_pkg::THR_W-1:0] thr;
  logic [TCW-1:0] track_count, t_idx;
  logic [DCW-1:0] det_count, d_idx;
  logic [mnna_pkg::PAIR_W-1:0] pairs;

  logic                        have;
  logic [DAW-1:0]              best;
  logic [mnna_pkg::DIST_W-1:0] best_dist;
  logic                        pend_valid;
  mnna_pkg::result_t           pend;

  logic [mnna_pkg::SQ_W-1:0] sx, sy;
  logic [mnna_pkg::SQ_W-1:0] qx, qy;
  logic                      busy_x, busy_y;

  logic signed [mnna_pkg::POS_W:0] dx, dy;
  logic [mnna_pkg::POS_W-1:0]      mx, my;
  logic [mnna_pkg::SQ_W:0]         esum;
  logic [mnna_pkg::DIST_W-1:0]     dist_new;
  logic                            better;
  logic                            trk_full, det_full;

  assign trk_full = (track_count == TCW'(MAX_TRACKS));
  assign det_full = (det_count == DCW'(MAX_DETECTIONS));

  // Differences are taken as magnitudes; every one fits in 16 bits.
  assign dx = {det_q.x[mnna_pkg::POS_W-1], det_q.x} - {trk_q.x[mnna_pkg::POS_W-1], trk_q.x};
  assign dy = {det_q.y[mnna_pkg::POS_W-1], det_q.y} - {trk_q.y[mnna_pkg::POS_W-1], trk_q.y};
  assign mx = dx[mnna_pkg::POS_W] ? mnna_pkg::POS_W'(-dx) : dx[mnna_pkg::POS_W-1:0];
  assign my = dy[mnna_pkg::POS_W] ? mnna_pkg::POS_W'(-dy) : dy[mnna_pkg::POS_W-1:0];

  assign esum     = {1'b0, sx} + {1'b0, sy};
  assign dist_new = stat.var_zero ? mnna_pkg::DIST_SAT
                                  : ({2'b00, qx} + {2'b00, qy});
  assign better   = !have || (dist_new < best_dist);

  always_comb begin
    stat.t_done     = (t_idx == track_count) ||
                      (pairs == mnna_pkg::PAIR_W'(mnna_pkg::RESULT_LIMIT));
    stat.d_done     = (d_idx == det_count);
    stat.taken      = taken_q;
    stat.gate_pass  = esum <= {8'd0, thr, 9'd0};
    stat.var_zero   = (trk_q.vx == '0) || (trk_q.vy == '0);
    stat.div_busy   = busy_x || busy_y;
    stat.pair_ok    = have && (best_dist < {18'd0, thr});
    stat.pend_valid = pend_valid;
    stat.out_free   = !out_valid || out_ready;
  end

  mnna_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sx),
    .divisor  (trk_q.vx),
    .busy     (busy_x),
    .quotient (qx)
  );

  mnna_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sy),
    .divisor  (trk_q.vy),
    .busy     (busy_y),
    .quotient (qy)
  );

  // Memories: one write port for loads, one registered read port each.
  always_ff @(posedge clk) begin
    if (cmd.load_trk && !trk_full) begin
      trk_mem[track_count[TAW-1:0]] <= '{x: item.pos_x, y: item.pos_y,
                                         vx: item.var_x, vy: item.var_y};
    end
    if (cmd.t_rd) begin
      trk_q <= trk_mem[t_idx[TAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_det && !det_full) begin
      det_mem[det_count[DAW-1:0]] <= '{x: item.pos_x, y: item.pos_y};
    end
    if (cmd.d_rd) begin
      det_q   <= det_mem[d_idx[DAW-1:0]];
      taken_q <= taken[d_idx[DAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      sx <= mx * mx;
      sy <= my * my;
    end
    if (cmd.upd && better) begin
      best      <= d_idx[DAW-1:0];
      best_dist <= dist_new;
    end
    if (cmd.pair) begin
      pend <= '{det_index: 5'(best), track_index: 5'(t_idx), matched: 1'b1, last: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr         <= mnna_pkg::THRESH_RESET;
      track_count <= '0;
      det_count   <= '0;
      t_idx       <= '0;
      d_idx       <= '0;
      pairs       <= '0;
      have        <= 1'b0;
      taken       <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thr <= cfg_data;
      end
      if (cmd.load_trk && !trk_full) begin
        track_count <= track_count + 1'b1;
      end
      if (cmd.load_det && !det_full) begin
        det_count <= det_count + 1'b1;
      end
      if (cmd.run_start) begin
        t_idx      <= '0;
        pairs      <= '0;
        taken      <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.t_next) begin
        t_idx <= t_idx + 1'b1;
      end
      if (cmd.t_rd) begin
        d_idx <= '0;
        have  <= 1'b0;
      end
      if (cmd.d_next) begin
        d_idx <= d_idx + 1'b1;
      end
      if (cmd.upd && better) begin
        have <= 1'b1;
      end
      if (cmd.pair) begin
        taken[best] <= 1'b1;
        pairs       <= pairs + 1'b1;
        pend_valid  <= 1'b1;
      end
      if (cmd.fin) begin
        track_count <= '0;
        det_count   <= '0;
        taken       <= '0;
      end
      // The previous pair is only known not to be the last once a new one
      // is found, so it moves to the output then.
      if ((cmd.pair && pend_valid) || cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pair && pend_valid) begin
      result <= pend;
    end else if (cmd.fin) begin
      if (pend_valid) begin
        result <= '{det_index: pend.det_index, track_index: pend.track_index,
                    matched: 1'b1, last: 1'b1};
      end else begin
        result <= '{det_index: '0, track_index: '0, matched: 1'b0, last: 1'b1};
      end
    end
  end

endmodule

// File: hdl/mnna_ctrl.sv
// ---------------------------------------------------------------------------
// mnna_ctrl
// Controller: sequences loads and the track-by-detection association scan.
// ---------------------------------------------------------------------------
module mnna_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  mnna_pkg::op_t     op,
  output logic              in_ready,
  output mnna_pkg::cmd_t    cmd,
  input  mnna_pkg::status_t stat
);

  mnna_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnna_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      mnna_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op)
            mnna_pkg::OP_TRACK: cmd.load_trk = 1'b1;
            mnna_pkg::OP_DET:   cmd.load_det = 1'b1;
            mnna_pkg::OP_RUN: begin
              cmd.run_start = 1'b1;
              state_next    = mnna_pkg::S_T_CHK;
            end
            default: ;
          endcase
        end
      end
      mnna_pkg::S_T_CHK: begin
        if (stat.t_done) begin
          state_next = mnna_pkg::S_FIN;
        end else begin
          cmd.t_rd   = 1'b1;
          state_next = mnna_pkg::S_D_CHK;
        end
      end
      mnna_pkg::S_D_CHK: begin
        if (stat.d_done) begin
          state_next = mnna_pkg::S_T_END;
        end else begin
          cmd.d_rd   = 1'b1;
          state_next = mnna_pkg::S_D_SQ;
        end
      end
      mnna_pkg::S_D_SQ: begin
        if (stat.taken) begin
          cmd.d_next = 1'b1;
          state_next = mnna_pkg::S_D_CHK;
        end else begin
          cmd.sq_en  = 1'b1;
          state_next = mnna_pkg::S_D_GATE;
        end
      end
      mnna_pkg::S_D_GATE: begin
        if (!stat.gate_pass) begin
          cmd.d_next = 1'b1;
          state_next = mnna_pkg::S_D_CHK;
        end else if (stat.var_zero) begin
          // A zero variance saturates the distance, no division needed.
          cmd.upd    = 1'b1;
          cmd.d_next = 1'b1;
          state_next = mnna_pkg::S_D_CHK;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = mnna_pkg::S_D_DIV;
        end
      end
      mnna_pkg::S_D_DIV: begin
        if (!stat.div_busy) begin
          cmd.upd    = 1'b1;
          cmd.d_next = 1'b1;
          state_next = mnna_pkg::S_D_CHK;
        end
      end
      mnna_pkg::S_T_END: begin
        if (!stat.pair_ok) begin
          cmd.t_next = 1'b1;
          state_next = mnna_pkg::S_T_CHK;
        end else if (!stat.pend_valid || stat.out_free) begin
          cmd.pair   = 1'b1;
          cmd.t_next = 1'b1;
          state_next = mnna_pkg::S_T_CHK;
        end
      end
      mnna_pkg::S_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = mnna_pkg::S_IDLE;
        end
      end
      default: state_next = mnna_pkg::S_IDLE;
    endcase
  end

endmodule

// File: hdl/mnna_checker.sv
// ---------------------------------------------------------------------------
// mnna_checker
// Port-level checks of the association block, bound to the top level.
// ---------------------------------------------------------------------------
`include "mahalanobis_nearest_neighbor_assoc_assert.svh"

module mnna_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input mnna_pkg::item_t   item,
  input logic              out_valid,
  input logic              out_ready,
  input mnna_pkg::result_t result
);

  // A held word keeps its payload.
  `MNNA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result))
  // An empty run reports zero indices and closes the run.
  `MNNA_ASSERT_NOW(a_empty_last, out_valid && !result.matched, result.last && result.det_index == '0 && result.track_index == '0)
  // An accepted run always keeps the block busy in the next cycle.
  `MNNA_ASSERT_NEXT(a_run_busy, in_valid && in_ready && item.op == mnna_pkg::OP_RUN, !in_ready)
  // Nothing is shown right after reset.
  `MNNA_ASSERT_NOW(a_reset_quiet, $past(rst), !out_valid)

endmodule

bind mahalanobis_nearest_neighbor_assoc mnna_checker u_mnna_checker (.*);

// File: sim/mnna_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mnna_scoreboard
// Watches the item, result and threshold channels of the association block,
// predicts the pairs of every run and compares them with the result words.
// ---------------------------------------------------------------------------
module mnna_scoreboard (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  mnna_pkg::item_t            item,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  mnna_pkg::result_t          result,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [mnna_pkg::THR_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending
);

  localparam int NSLOT = 32;

  logic [15:0] gate;
  logic [15:0] trk_x [NSLOT];
  logic [15:0] trk_y [NSLOT];
  logic [15:0] trk_vx [NSLOT];
  logic [15:0] trk_vy [NSLOT];
  logic [15:0] det_x [NSLOT];
  logic [15:0] det_y [NSLOT];
  int n_trk, n_det;
  mnna_pkg::result_t pair_q [$];

  function automatic longint unsigned sq_diff(logic [15:0] a, logic [15:0] b);
    longint signed d;
    d = longint'($signed(a)) - longint'($signed(b));
    return $unsigned(d * d);
  endfunction

  // Greedy association over the loaded lists; queues the expected words.
  task automatic associate();
    bit taken [NSLOT];
    int n;
    bit have;
    int best;
    longint unsigned best_d, sx, sy, mdist;
    mnna_pkg::result_t r;
    n = 0;
    foreach (taken[i]) taken[i] = 0;
    for (int t = 0; t < n_trk && n < mnna_pkg::RESULT_LIMIT; t++) begin
      have = 0;
      best = 0;
      best_d = 0;
      for (int d = 0; d < n_det; d++) begin
        if (taken[d]) continue;
        sx = sq_diff(det_x[d], trk_x[t]);
        sy = sq_diff(det_y[d], trk_y[t]);
        if (sx + sy > (64'(gate) << 9)) continue;
        if (trk_vx[t] == 0 || trk_vy[t] == 0) mdist = 64'hFFFF_FFFF_FFFF;
        else mdist = sx / 64'(trk_vx[t]) + sy / 64'(trk_vy[t]);
        if (!have || mdist < best_d) begin
          have = 1;
          best = d;
          best_d = mdist;
        end
      end
      if (have && best_d < 64'(gate)) begin
        taken[best] = 1;
        r.det_index = best[4:0];
        r.track_index = t[4:0];
        r.matched = 1'b1;
        r.last = 1'b0;
        pair_q = {pair_q, r};
        n++;
      end
    end
    if (n == 0) begin
      r = '0;
      pair_q = {pair_q, r};
    end
    pair_q[pair_q.size()-1].last = 1'b1;
    n_trk = 0;
    n_det = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gate <= mnna_pkg::THRESH_RESET;
      n_trk = 0;
      n_det = 0;
      errors = 0;
      pair_q.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) gate <= cfg_data;
      if (in_valid && in_ready) begin
        case (item.op)
          mnna_pkg::OP_TRACK: if (n_trk < NSLOT) begin
            trk_x[n_trk] = item.pos_x;
            trk_y[n_trk] = item.pos_y;
            trk_vx[n_trk] = item.var_x;
            trk_vy[n_trk] = item.var_y;
            n_trk++;
          end
          mnna_pkg::OP_DET: if (n_det < NSLOT) begin
            det_x[n_det] = item.pos_x;
            det_y[n_det] = item.pos_y;
            n_det++;
          end
          mnna_pkg::OP_RUN: associate();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pair_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %p", $time, result);
          errors++;
        end else begin
          if (result !== pair_q[0]) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, pair_q[0], result);
            errors++;
          end
          void'(pair_q.pop_front());
        end
      end
      pending = pair_q.size();
    end
  end
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives track, detection, unused-op and run words with random gaps and stalls through
// several thresholds; the checker predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  mnna_pkg::item_t item = '0;
  logic out_valid;
  logic out_ready = 0;
  mnna_pkg::result_t result;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [mnna_pkg::THR_W-1:0] cfg_data = '0;
  int errors, pending;
  bit quiet = 0;
  bit hold_rx = 0;
  int idle_cyc = 0;
  int sent = 0;

  always #2 clk = ~clk;

  mahalanobis_nearest_neighbor_assoc i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .item(item),
    .out_valid(out_valid), .out_ready(out_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  mnna_scoreboard i_chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .item(item),
    .out_valid(out_valid), .out_ready(out_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // Receiver: random stall bursts, a long hold-off on request, none at the end.
  always begin
    int n;
    @(posedge clk);
    if (hold_rx) begin
      out_ready <= 1'b0;
      repeat (400) @(posedge clk);
      hold_rx = 0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 10);
      out_ready <= 1'b0;
      repeat (n) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // Valid stays up between back-to-back words and drops only for a gap.
  task automatic send(mnna_pkg::op_t op, logic [15:0] x, logic [15:0] y,
                      logic [15:0] vx, logic [15:0] vy);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    item <= '{op: op, pos_x: x, pos_y: y, var_x: vx, var_y: vy};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic set_gate(logic [15:0] g);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_data <= g;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One frame: detections near the tracks so that pairs form, some noise.
  task automatic frame(int nt, int nd);
    logic [15:0] bx, by, v, vy, px, py;
    logic [15:0] cx [32];
    logic [15:0] cy [32];
    bx = rnd16();
    by = rnd16();
    for (int i = 0; i < nt; i++) begin
      cx[i % 32] = bx + 16'($urandom_range(0, 4096));
      cy[i % 32] = by + 16'($urandom_range(0, 4096));
      v = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(32, 1024));
      vy = ($urandom_range(0, 20) == 0) ? rnd16() : v;
      send(mnna_pkg::OP_TRACK, cx[i % 32], cy[i % 32], v, vy);
    end
    for (int i = 0; i < nd; i++) begin
      if (nt > 0 && $urandom_range(0, 5) != 0) begin
        px = cx[$urandom_range(0, nt-1) % 32] + 16'($urandom_range(0, 800)) - 16'd400;
        py = cy[$urandom_range(0, nt-1) % 32] + 16'($urandom_range(0, 800)) - 16'd400;
        send(mnna_pkg::OP_DET, px, py, rnd16(), rnd16());
      end else begin
        send(mnna_pkg::OP_DET, rnd16(), rnd16(), rnd16(), rnd16());
      end
    end
    if ($urandom_range(0, 9) == 0)
      send(mnna_pkg::OP_NONE, rnd16(), rnd16(), rnd16(), rnd16());
    send(mnna_pkg::OP_RUN, rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: empty run, field extremes, zero variance, unused op.
    send(mnna_pkg::OP_RUN, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(mnna_pkg::OP_TRACK, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    send(mnna_pkg::OP_DET, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    send(mnna_pkg::OP_TRACK, 16'h0000, 16'h0000, 16'h0000, 16'h0100);
    send(mnna_pkg::OP_DET, 16'h0010, 16'h0000, 16'h0000, 16'h0000);
    send(mnna_pkg::OP_TRACK, 16'h8000, 16'h7FFF, 16'h0001, 16'h0001);
    send(mnna_pkg::OP_DET, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);
    send(mnna_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(mnna_pkg::OP_RUN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Full lists: 33 tracks and 33 detections, the last of each dropped.
    for (int i = 0; i < 33; i++)
      send(mnna_pkg::OP_TRACK, 16'(i * 256), 16'h0000, 16'h0100, 16'h0100);
    for (int i = 0; i < 33; i++)
      send(mnna_pkg::OP_DET, 16'(i * 256 + 16), 16'h0000, 16'h0, 16'h0);
    send(mnna_pkg::OP_RUN, 16'h0, 16'h0, 16'h0, 16'h0);
    set_gate(16'hFFFF);
    frame(4, 4);
    set_gate(16'h0000);
    frame(3, 3);
    set_gate(16'h0001);
    frame(3, 3);
    // Long output hold-off while the input keeps offering frames.
    set_gate(16'd1152);
    hold_rx = 1;
    frame(10, 10);
    frame(10, 10);
    while (sent < 420) begin
      if ($urandom_range(0, 7) == 0) set_gate($urandom_range(0, 3) == 0 ? rnd16()
                                             : 16'($urandom_range(64, 4096)));
      frame($urandom_range(0, 8), $urandom_range(0, 8));
    end
    quiet = 1;
    while (sent < 520) frame($urandom_range(1, 8), $urandom_range(1, 8));
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule
